[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold on the same edge as the antecedent
`define TQLA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tqla assertion failed");

// consequent must hold on the edge after the antecedent
`define TQLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tqla assertion failed");

`endif

[rtl/core/tqla_pkg.sv]
// ----------------------------------------------------------------------------
// tqla_pkg
// Field types, register indexes and fixed constants of the Q-learning agent.
// ----------------------------------------------------------------------------
package tqla_pkg;

  // field widths
  localparam int COMP_W    = 16;
  localparam int ACT_W     = 3;
  localparam int REWARD_W  = 20;
  localparam int Q_W       = 32;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int RAND_W    = 32;

  typedef logic        [COMP_W-1:0]    comp_t;
  typedef logic        [ACT_W-1:0]     act_t;
  typedef logic signed [REWARD_W-1:0]  reward_t;
  typedef logic signed [Q_W-1:0]       q_t;
  typedef logic        [FRAC_W-1:0]    frac_t;
  typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic        [RAND_W-1:0]    rand_t;

  // configuration register indexes
  localparam cfg_idx_t CFG_LEARNING_RATE = 2'd0;
  localparam cfg_idx_t CFG_DISCOUNT      = 2'd1;
  localparam cfg_idx_t CFG_EXPLORE       = 2'd2;

  // register values after reset
  localparam frac_t LR_RESET       = 16'd6554;
  localparam frac_t DISCOUNT_RESET = 16'd58982;
  localparam frac_t EXPLORE_RESET  = 16'd6554;

  // saturation bounds of a Q value
  localparam q_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN = 32'sh8000_0000;

endpackage

[rtl/core/tabular_q_learning_agent_unit.sv]
// ----------------------------------------------------------------------------
// tabular_q_learning_agent_unit
// Epsilon-greedy action selection and Q-learning updates on a Q table.
// ----------------------------------------------------------------------------
// From the accepting edge to done: an exploring select or a bad update action
// passes S_ROW and S_DISP, a greedy select adds the one-entry-a-cycle row scan,
// and an update adds the scan, S_RDCUR and the two-multiplier chain to S_FIN.
// One request at a time: the next is taken at the edge ending the done cycle;
// results are never held off by the receiver.
// Reset clears the table one row a cycle, busy until every row is cleared.
module tabular_q_learning_agent_unit #(
  parameter int LEVELS  = 10,
  parameter int DIMS    = 4,
  parameter int ACTIONS = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  // request
  input  logic                       start,
  output logic                       busy,
  input  logic                       action,
  input  tqla_pkg::comp_t            cur_snr,
  input  tqla_pkg::comp_t            cur_sf,
  input  tqla_pkg::comp_t            cur_power,
  input  tqla_pkg::comp_t            cur_rssi,
  input  tqla_pkg::act_t             taken_action,
  input  tqla_pkg::reward_t          reward,
  input  tqla_pkg::comp_t            next_snr,
  input  tqla_pkg::comp_t            next_sf,
  input  tqla_pkg::comp_t            next_power,
  input  tqla_pkg::comp_t            next_rssi,
  input  tqla_pkg::rand_t            rand_bits,
  // configuration
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  tqla_pkg::cfg_idx_t         cfg_index,
  input  tqla_pkg::frac_t            cfg_data,
  // result
  output logic                       done,
  output tqla_pkg::act_t             chosen_action,
  output logic                       explored,
  output tqla_pkg::q_t               new_q
);

  localparam int ACT_IDX_W = $clog2(ACTIONS);
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int ROWS      = LEVELS ** DIMS;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int unsigned WEIGHT [4] = '{1, LEVELS, LEVELS * LEVELS,
                                         LEVELS * LEVELS * LEVELS};
  localparam logic [ROW_W-1:0]     ROW_LAST  = ROW_W'(ROWS - 1);
  localparam logic [ACT_IDX_W-1:0] SCAN_LAST = ACT_IDX_W'(ACTIONS - 1);
  localparam logic signed [36:0]   SAT_HI    = 37'(tqla_pkg::Q_MAX);
  localparam logic signed [36:0]   SAT_LO    = 37'(tqla_pkg::Q_MIN);

  // sequencer states
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ROW   = 4'd2;
  localparam logic [3:0] S_DISP  = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_RDCUR = 4'd5;
  localparam logic [3:0] S_MUL1  = 4'd6;
  localparam logic [3:0] S_DIFF  = 4'd7;
  localparam logic [3:0] S_MUL2  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  typedef logic [ACTIONS-1:0][tqla_pkg::Q_W-1:0] row_t;

  logic [3:0]           state;
  logic [3:0]           state_next;
  logic [ROW_W-1:0]     clr_row;
  tqla_pkg::frac_t      lr;
  tqla_pkg::frac_t      gamma;
  tqla_pkg::frac_t      eps;

  // latched request
  logic                 action_r;
  tqla_pkg::act_t       act_r;
  tqla_pkg::reward_t    reward_r;
  logic                 explore_r;
  logic [ACT_IDX_W-1:0] explore_act;
  logic [LVL_W-1:0]     cur_lvl  [DIMS];
  logic [LVL_W-1:0]     next_lvl [DIMS];
  logic [ROW_W-1:0]     cur_row;
  logic [ROW_W-1:0]     next_row;

  // scan and arithmetic
  logic [ACT_IDX_W-1:0] idx;
  tqla_pkg::q_t         best;
  logic [ACT_IDX_W-1:0] pick;
  tqla_pkg::q_t         q_cur;
  logic signed [48:0]   prod1;
  logic signed [34:0]   diff;
  logic signed [51:0]   prod2;

  // table memory
  row_t                 qmem [ROWS];
  row_t                 rd_data;
  logic                 re;
  logic [ROW_W-1:0]     raddr;
  logic                 we;
  logic [ROW_W-1:0]     waddr;
  row_t                 wdata;

  tqla_pkg::comp_t      cur_comp  [4];
  tqla_pkg::comp_t      next_comp [4];
  logic                 accept;
  logic                 act_ok;
  logic [18:0]          ex_prod;
  logic [ROW_W-1:0]     cur_row_calc;
  logic [ROW_W-1:0]     next_row_calc;
  tqla_pkg::q_t         lane;
  logic                 take;
  tqla_pkg::q_t         best_next;
  logic [ACT_IDX_W-1:0] pick_next;
  logic                 scan_last;
  logic signed [36:0]   nq_wide;
  tqla_pkg::q_t         nq_sat;
  row_t                 row_upd;
  logic                 done_next;
  tqla_pkg::act_t       res_action;
  logic                 res_explored;
  tqla_pkg::q_t         res_q;

  // level of one state component: floor(v * LEVELS / 4096) mod LEVELS
  function automatic logic [LVL_W-1:0] level_of(input tqla_pkg::comp_t v);
    logic [19:0] prod;
    logic [7:0]  rem;
    prod = 20'(v) * 20'(LEVELS);
    rem  = prod[19:12];
    for (int k = 3; k >= 0; k--) begin
      if (9'(rem) >= 9'(LEVELS << k)) begin
        rem = rem - 8'(LEVELS << k);
      end
    end
    return rem[LVL_W-1:0];
  endfunction

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && (state == S_IDLE);
  assign act_ok    = (4'(act_r) < 4'(ACTIONS));
  assign scan_last = (idx == SCAN_LAST);
  assign ex_prod   = 19'(rand_bits[15:0]) * 19'(ACTIONS);

  assign cur_comp  = '{cur_snr, cur_sf, cur_power, cur_rssi};
  assign next_comp = '{next_snr, next_sf, next_power, next_rssi};

  // row index from the latched levels
  always_comb begin
    cur_row_calc  = '0;
    next_row_calc = '0;
    for (int i = 0; i < DIMS; i++) begin
      cur_row_calc  = cur_row_calc  + ROW_W'(cur_lvl[i]  * WEIGHT[i]);
      next_row_calc = next_row_calc + ROW_W'(next_lvl[i] * WEIGHT[i]);
    end
  end

  // one compare a cycle over the row: first strictly greatest wins
  always_comb begin
    lane      = $signed(rd_data[idx]);
    take      = (idx == '0) || (lane > best);
    best_next = take ? lane : best;
    pick_next = take ? idx : pick;
  end

  // final sum with saturation and the row to write back
  always_comb begin
    nq_wide = 37'(q_cur) + 37'($signed(prod2[51:16]));
    if (nq_wide > SAT_HI) begin
      nq_sat = tqla_pkg::Q_MAX;
    end else if (nq_wide < SAT_LO) begin
      nq_sat = tqla_pkg::Q_MIN;
    end else begin
      nq_sat = nq_wide[31:0];
    end
    row_upd = rd_data;
    row_upd[act_r[ACT_IDX_W-1:0]] = nq_sat;
  end

  // memory port control
  always_comb begin
    re    = 1'b0;
    raddr = cur_row;
    we    = 1'b0;
    waddr = cur_row;
    wdata = row_upd;
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_row;
        wdata = '0;
      end
      S_DISP: begin
        re    = action_r ? act_ok : !explore_r;
        raddr = action_r ? next_row : cur_row;
      end
      S_RDCUR: begin
        re = 1'b1;
      end
      S_FIN: begin
        we = 1'b1;
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  // next state and result
  always_comb begin
    state_next   = state;
    done_next    = 1'b0;
    res_action   = '0;
    res_explored = 1'b0;
    res_q        = '0;
    case (state)
      S_CLEAR: begin
        if (clr_row == ROW_LAST) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_ROW;
      end
      S_ROW: begin
        state_next = S_DISP;
      end
      S_DISP: begin
        if (!action_r && explore_r) begin
          state_next   = S_IDLE;
          done_next    = 1'b1;
          res_action   = tqla_pkg::ACT_W'(explore_act);
          res_explored = 1'b1;
        end else if (action_r && !act_ok) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          if (action_r) begin
            state_next = S_RDCUR;
          end else begin
            state_next = S_IDLE;
            done_next  = 1'b1;
            res_action = tqla_pkg::ACT_W'(pick_next);
            res_q      = best_next;
          end
        end
      end
      S_RDCUR: state_next = S_MUL1;
      S_MUL1:  state_next = S_DIFF;
      S_DIFF:  state_next = S_MUL2;
      S_MUL2:  state_next = S_FIN;
      S_FIN: begin
        state_next = S_IDLE;
        done_next  = 1'b1;
        res_q      = nq_sat;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_row <= '0;
      done    <= 1'b0;
      lr      <= tqla_pkg::LR_RESET;
      gamma   <= tqla_pkg::DISCOUNT_RESET;
      eps     <= tqla_pkg::EXPLORE_RESET;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == S_CLEAR) clr_row <= clr_row + 1'b1;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tqla_pkg::CFG_LEARNING_RATE: lr    <= cfg_data;
          tqla_pkg::CFG_DISCOUNT:      gamma <= cfg_data;
          tqla_pkg::CFG_EXPLORE:       eps   <= cfg_data;
          default:                     lr    <= lr;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      action_r    <= action;
      act_r       <= taken_action;
      reward_r    <= reward;
      explore_r   <= (rand_bits[31:16] < eps);
      explore_act <= ex_prod[16 +: ACT_IDX_W];
      for (int i = 0; i < DIMS; i++) begin
        cur_lvl[i]  <= level_of(cur_comp[i]);
        next_lvl[i] <= level_of(next_comp[i]);
      end
    end
    if (state == S_ROW) begin
      cur_row  <= cur_row_calc;
      next_row <= next_row_calc;
    end
    if (state == S_DISP) idx <= '0;
    if (state == S_SCAN) begin
      idx  <= idx + 1'b1;
      best <= best_next;
      pick <= pick_next;
    end
    // gamma * max Q(next), then target minus Q, then lr * difference
    if (state == S_MUL1) begin
      q_cur <= $signed(rd_data[act_r[ACT_IDX_W-1:0]]);
      prod1 <= $signed({1'b0, gamma}) * best;
    end
    if (state == S_DIFF) begin
      diff <= 35'(reward_r) + 35'($signed(prod1[48:16])) - 35'(q_cur);
    end
    if (state == S_MUL2) begin
      prod2 <= $signed({1'b0, lr}) * diff;
    end
    if (done_next) begin
      chosen_action <= res_action;
      explored      <= res_explored;
      new_q         <= res_q;
    end
  end

  // table memory, one read and one write port
  always_ff @(posedge clk) begin
    if (we) qmem[waddr] <= wdata;
    if (re) rd_data <= qmem[raddr];
  end

endmodule

[rtl/core/tqla_checker.sv]
// ----------------------------------------------------------------------------
// tqla_checker
// Port-level checks of the Q-learning agent, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tqla_checker #(
  parameter int ACTIONS = 5
) (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input tqla_pkg::act_t chosen_action,
  input logic           explored,
  input tqla_pkg::q_t   new_q
);

  // an accepted request keeps the block busy on the next cycle
  `TQLA_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

  // a result only ends a busy stretch
  `TQLA_ASSERT_NOW(a_done_after_busy, clk, rst, done, $past(busy))

  // exploring selects report a zero Q value
  `TQLA_ASSERT_NOW(a_explore_zero_q, clk, rst, done && explored, new_q == '0)

  // chosen action is always a legal one
  `TQLA_ASSERT_NOW(a_action_range, clk, rst, done, 4'(chosen_action) < 4'(ACTIONS))

  // a result is never directly followed by another
  `TQLA_ASSERT_NEXT(a_done_single, clk, rst, done, !done)

endmodule

bind tabular_q_learning_agent_unit tqla_checker #(.ACTIONS(ACTIONS)) u_tqla_checker (.*);
